FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ETC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ETC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/etc_pkg.sv
// Shared types and constants for the epoch-seconds to calendar pipeline.
// No dependencies.
package etc_pkg;

    localparam int PIPE_DEPTH = 6;

    // Exact reciprocals: floor(x/d) = (x * ceil(2^(N+l)/d)) >> (N+l),
    // x < 2^N, 2^l >= d.
    localparam int DAY_SHIFT  = 48;
    localparam logic [31:0] DAY_MUL   = 32'(((64'd1 << 48) + 64'd86399) / 64'd86400);
    localparam int WEEK_SHIFT = 18;
    localparam logic [19:0] WEEK_MUL  = 20'(((64'd1 << 18) + 64'd6) / 64'd7);
    localparam int Q1460_SHIFT = 29;
    localparam logic [19:0] Q1460_MUL = 20'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam int Q36500_SHIFT = 34;
    localparam logic [19:0] Q36500_MUL = 20'(((64'd1 << 34) + 64'd36499) / 64'd36500);
    localparam int Q146000_SHIFT = 36;
    localparam logic [19:0] Q146000_MUL = 20'(((64'd1 << 36) + 64'd145999) / 64'd146000);
    localparam int YEAR_SHIFT = 27;
    localparam logic [19:0] YEAR_MUL  = 20'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam int HOUR_SHIFT = 29;
    localparam logic [19:0] HOUR_MUL  = 20'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam int MIN_SHIFT  = 18;
    localparam logic [19:0] MIN_MUL   = 20'(((64'd1 << 18) + 64'd59) / 64'd60);

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [17:0] DAYS_1601_TO_1970 = 18'd134774;

    typedef struct packed {
        logic [30:0] epoch_seconds;
        logic [29:0] nanoseconds_in;
    } t_etc_in;

    typedef struct packed {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [2:0]  weekday;
        logic [7:0]  years_since_1900;
        logic [8:0]  day_of_year;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [29:0] nanoseconds_out;
    } t_etc_out;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;   // stage loads this cycle
        logic [PIPE_DEPTH-1:0] vld;  // stage holds a request
    } t_pipe_ctl;

endpackage

FILE: sv/etc_pipe_ctl.sv
// Valid/ready control for the calendar pipeline: per-stage valid bits and
// load enables, bubbles collapse. Depends on etc_pkg.
module etc_pipe_ctl import etc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH-1:0] rdy;
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] prev_vld;

    always_comb begin
        rdy[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_comb begin
        prev_vld = {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        en       = prev_vld & rdy;
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            n_vld[k] = rdy[k] ? prev_vld[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = rdy[0];
    assign o_ctl.en   = en;
    assign o_ctl.vld  = r_vld;

endmodule

FILE: sv/etc_clock_path.sv
// Time-of-day datapath, stages 2..6: seconds of day, then hour, minute, second.
// Depends on etc_pkg.
module etc_clock_path import etc_pkg::*; (
    input  logic        i_clk,
    input  t_pipe_ctl   i_ctl,
    input  logic [30:0] i_secs,
    input  logic [14:0] i_days,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic [16:0] r2_sod;
    logic [16:0] r3_sod;
    logic [4:0]  r3_hour;
    logic [11:0] r4_rem;
    logic [4:0]  r4_hour;
    logic [11:0] r5_rem;
    logic [5:0]  r5_min;
    logic [4:0]  r5_hour;
    logic [5:0]  r6_sec;
    logic [5:0]  r6_min;
    logic [4:0]  r6_hour;

    logic [31:0] day_base;
    logic [36:0] hour_prod;
    logic [31:0] min_prod;
    logic [16:0] hour_base;

    assign day_base  = 32'(i_days) * 32'(SEC_PER_DAY);
    assign hour_prod = 37'(r2_sod) * 37'(HOUR_MUL);
    assign hour_base = 17'(r3_hour) * SEC_PER_HOUR;
    assign min_prod  = 32'(r4_rem) * 32'(MIN_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_sod <= 17'(32'(i_secs) - day_base);
        end
        if (i_ctl.en[2]) begin
            r3_sod  <= r2_sod;
            r3_hour <= 5'(hour_prod >> HOUR_SHIFT);
        end
        if (i_ctl.en[3]) begin
            r4_rem  <= 12'(r3_sod - hour_base);
            r4_hour <= r3_hour;
        end
        if (i_ctl.en[4]) begin
            r5_rem  <= r4_rem;
            r5_min  <= 6'(min_prod >> MIN_SHIFT);
            r5_hour <= r4_hour;
        end
        if (i_ctl.en[5]) begin
            r6_sec  <= 6'(r5_rem - 12'(r5_min) * 12'd60);
            r6_min  <= r5_min;
            r6_hour <= r5_hour;
        end
    end

    assign o_hour   = r6_hour;
    assign o_minute = r6_min;
    assign o_second = r6_sec;

endmodule

FILE: sv/etc_date_path.sv
// Date datapath, stages 2..6: weekday, year from the 1601-based day count,
// day of year, leap flag and month lookup. Depends on etc_pkg.
module etc_date_path import etc_pkg::*; (
    input  logic        i_clk,
    input  t_pipe_ctl   i_ctl,
    input  logic [14:0] i_days,
    output logic [2:0]  o_weekday,
    output logic [7:0]  o_year,
    output logic [8:0]  o_yday,
    output logic [3:0]  o_month,
    output logic [4:0]  o_mday
);

    // First day of month idx (idx 12 is the year length).
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        return base + 9'((leap && idx >= 4'd2) ? 1 : 0);
    endfunction

    logic [14:0] r2_d4;
    logic [12:0] r2_wq;
    logic [17:0] r2_i;
    logic [6:0]  r2_qa;
    logic [2:0]  r2_qb;
    logic        r2_qc;
    logic [2:0]  r3_wday;
    logic [17:0] r3_t;
    logic [17:0] r3_i;
    logic [2:0]  r4_wday;
    logic [8:0]  r4_ny;
    logic [17:0] r4_i;
    logic [2:0]  r5_wday;
    logic [7:0]  r5_year;
    logic [8:0]  r5_yday;
    logic        r5_leap;
    logic [2:0]  r6_wday;
    logic [7:0]  r6_year;
    logic [8:0]  r6_yday;
    logic [3:0]  r6_month;
    logic [4:0]  r6_mday;

    logic [14:0] d4;
    logic [17:0] day_i;
    logic [34:0] wk_prod;
    logic [37:0] qa_prod;
    logic [37:0] qb_prod;
    logic [37:0] qc_prod;
    logic [37:0] yr_prod;
    logic [2:0]  c100;
    logic        c400;
    logic [9:0]  n1;
    logic        leap;
    logic [3:0]  mcnt;
    logic [3:0]  month;
    logic [8:0]  mrem;

    // days stays below 24856 for any 31-bit input, so neither sum wraps
    assign d4      = i_days + 15'd4;
    assign day_i   = 18'(i_days) + DAYS_1601_TO_1970;
    assign wk_prod = 35'(d4) * 35'(WEEK_MUL);
    assign qa_prod = 38'(day_i) * 38'(Q1460_MUL);
    assign qb_prod = 38'(day_i) * 38'(Q36500_MUL);
    assign qc_prod = 38'(day_i) * 38'(Q146000_MUL);
    assign yr_prod = 38'(r3_t) * 38'(YEAR_MUL);

    // year count stays below 438: the century terms are threshold tests
    always_comb begin
        c100 = 3'(r4_ny >= 9'd100) + 3'(r4_ny >= 9'd200)
             + 3'(r4_ny >= 9'd300) + 3'(r4_ny >= 9'd400);
        c400 = (r4_ny >= 9'd400);
        n1   = 10'(r4_ny) + 10'd1;   // year - 1600
        leap = (n1[1:0] == 2'd0) && (n1 != 10'd100) && (n1 != 10'd200)
            && (n1 != 10'd300);
    end

    always_comb begin
        mcnt = '0;
        for (int k = 1; k <= 12; k++) begin
            mcnt = mcnt + 4'(r5_yday >= month_start(4'(k), r5_leap));
        end
        month = (mcnt > 4'd11) ? 4'd11 : mcnt;
        // past December the remainder is taken from the year length
        mrem  = r5_yday - month_start(mcnt, r5_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_d4 <= d4;
            r2_wq <= 13'(wk_prod >> WEEK_SHIFT);
            r2_i  <= day_i;
            r2_qa <= 7'(qa_prod >> Q1460_SHIFT);
            r2_qb <= 3'(qb_prod >> Q36500_SHIFT);
            r2_qc <= 1'(qc_prod >> Q146000_SHIFT);
        end
        if (i_ctl.en[2]) begin
            r3_wday <= 3'(r2_d4 - 15'(r2_wq) * 15'd7);
            r3_t    <= r2_i - 18'(r2_qa) + 18'(r2_qb) - 18'(r2_qc);
            r3_i    <= r2_i;
        end
        if (i_ctl.en[3]) begin
            r4_wday <= r3_wday;
            r4_ny   <= 9'(yr_prod >> YEAR_SHIFT);
            r4_i    <= r3_i;
        end
        if (i_ctl.en[4]) begin
            r5_wday <= r4_wday;
            r5_year <= 8'(r4_ny - 9'd299);
            r5_yday <= 9'(r4_i - 18'(r4_ny) * 18'd365 - 18'(r4_ny >> 2)
                          + 18'(c100) - 18'(c400));
            r5_leap <= leap;
        end
        if (i_ctl.en[5]) begin
            r6_wday  <= r5_wday;
            r6_year  <= r5_year;
            r6_yday  <= r5_yday;
            r6_month <= month;
            r6_mday  <= 5'(mrem + 9'd1);
        end
    end

    assign o_weekday = r6_wday;
    assign o_year    = r6_year;
    assign o_yday    = r6_yday;
    assign o_month   = r6_month;
    assign o_mday    = r6_mday;

endmodule

FILE: sv/epoch_seconds_to_calendar_top.sv
// Channel | direction | payload   | handshake
// in      | request   | t_etc_in  | i_in_valid / o_in_ready
// out     | result    | t_etc_out | o_out_valid / i_out_ready
//
// Six register stages; one request may enter every cycle while the pipeline is not full.
// Stage 1 is the day divide; later stages are each about one multiply deep,
// with the month compare in the last.
// A stalled output stage holds its result; upstream stages keep filling
// bubbles until the pipeline is full, then o_in_ready drops.
// Reset clears the valid bits only. Depends on etc_pkg, etc_pipe_ctl,
// etc_clock_path, etc_date_path and assert_macros.svh.
module epoch_seconds_to_calendar_top import etc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_etc_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_etc_out o_out_data
);

    `include "assert_macros.svh"

    t_pipe_ctl   ctl;
    logic [30:0] r1_secs;
    logic [14:0] r1_days;
    logic [29:0] r_ns [PIPE_DEPTH];
    logic [62:0] day_prod;

    etc_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    assign day_prod = 63'(i_in_data.epoch_seconds) * 63'(DAY_MUL);

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r1_secs <= i_in_data.epoch_seconds;
            r1_days <= 15'(day_prod >> DAY_SHIFT);
            r_ns[0] <= i_in_data.nanoseconds_in;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (ctl.en[k]) begin
                r_ns[k] <= r_ns[k-1];
            end
        end
    end

    etc_clock_path u_clock (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_secs   (r1_secs),
        .i_days   (r1_days),
        .o_hour   (o_out_data.hour_of_day),
        .o_minute (o_out_data.minute_of_hour),
        .o_second (o_out_data.second_of_minute)
    );

    etc_date_path u_date (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_days    (r1_days),
        .o_weekday (o_out_data.weekday),
        .o_year    (o_out_data.years_since_1900),
        .o_yday    (o_out_data.day_of_year),
        .o_month   (o_out_data.month_index),
        .o_mday    (o_out_data.day_of_month)
    );

    assign o_out_data.nanoseconds_out = r_ns[PIPE_DEPTH-1];
    assign o_out_valid                = ctl.vld[PIPE_DEPTH-1];

    `ETC_ASSERT(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready |-> ((&ctl.vld) && !i_out_ready), "input blocked while pipeline has room")
    `ETC_ASSERT(a_tod_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.second_of_minute < 6'd60 && o_out_data.minute_of_hour < 6'd60 && o_out_data.hour_of_day < 5'd24), "time of day out of range")
    `ETC_ASSERT(a_date_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.weekday < 3'd7 && o_out_data.month_index < 4'd12 && o_out_data.day_of_month != 5'd0), "date field out of range")
    `ETC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (ctl.vld == '0), "valid bits survive reset")

endmodule

FILE: verif/tb_top.sv
// Testbench for epoch_seconds_to_calendar_top: directed calendar edges, then random requests.
// Results are checked against a local calendar predictor with random stalls on both sides.
// Depends on etc_pkg and the epoch_seconds_to_calendar_top RTL.
module tb_top;
    import etc_pkg::*;

    localparam longint MAX_EPOCH    = 64'd2147483647;
    localparam longint SECS_PER_DAY = 64'd86400;
    localparam int     EPOCH_WDAY   = 4;          // 1970-01-01 was a Thursday
    localparam int     DRAIN_CYCLES = 20;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     RANDOM_ITEMS = 480;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_etc_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_etc_out o_out_data;

    t_etc_out pending_dates[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 35;
    int       recv_idle_pct = 77;

    epoch_seconds_to_calendar_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit is_leap_year(longint year);
        return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
    endfunction

    function automatic longint month_days(int mo, bit leap);
        case (mo)
            1:          return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
        endcase
    endfunction

    // Day number of 1 January of the given year, counted from 1970-01-01.
    function automatic longint year_start_days(int year);
        longint days;
        days = 0;
        for (int y = 1970; y < year; y++)
            days += is_leap_year(y) ? 366 : 365;
        return days;
    endfunction

    function automatic t_etc_out calendar_of(t_etc_in req);
        longint   secs, days, shifted, nyears, yday, year, rem;
        int       mo;
        bit       leap;
        t_etc_out r;
        secs = longint'(req.epoch_seconds);
        r.second_of_minute = 6'(secs % 60);
        secs /= 60;
        r.minute_of_hour = 6'(secs % 60);
        secs /= 60;
        r.hour_of_day = 5'(secs % 24);
        days = secs / 24;
        r.weekday = 3'((days + EPOCH_WDAY) % 7);
        // year estimate counted from 1601, where the 400-year cycle starts
        shifted = days + longint'(DAYS_1601_TO_1970);
        nyears = (shifted - shifted / 1460 + shifted / 36500 - shifted / 146000) / 365;
        yday = days - (nyears * 365 + nyears / 4 - nyears / 100 + nyears / 400
                       - longint'(DAYS_1601_TO_1970));
        year = nyears + 1601;
        leap = is_leap_year(year);
        rem = yday;
        mo = 0;
        while (mo < 12 && rem >= month_days(mo, leap)) begin
            rem -= month_days(mo, leap);
            mo++;
        end
        if (mo > 11)
            mo = 11;
        r.years_since_1900 = 8'(year - 1900);
        r.day_of_year = 9'(yday);
        r.month_index = 4'(mo);
        r.day_of_month = 5'(rem + 1);
        r.nanoseconds_out = req.nanoseconds_in;
        return r;
    endfunction

    task automatic send_request(longint epoch, logic [29:0] nsec);
        t_etc_in req;
        req.epoch_seconds = 31'(epoch);
        req.nanoseconds_in = nsec;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_dates.push_back(calendar_of(req));
    endtask

    task automatic check_field(string name, longint expected, longint actual);
        if (expected != actual) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
        end
    endtask

    // Output side: random stall, then compare each accepted result.
    always @(posedge i_clk) begin
        t_etc_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dates.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_data);
            end else begin
                want = pending_dates.pop_front();
                check_field("second_of_minute", want.second_of_minute,
                            o_out_data.second_of_minute);
                check_field("minute_of_hour", want.minute_of_hour,
                            o_out_data.minute_of_hour);
                check_field("hour_of_day", want.hour_of_day, o_out_data.hour_of_day);
                check_field("weekday", want.weekday, o_out_data.weekday);
                check_field("years_since_1900", want.years_since_1900,
                            o_out_data.years_since_1900);
                check_field("day_of_year", want.day_of_year, o_out_data.day_of_year);
                check_field("month_index", want.month_index, o_out_data.month_index);
                check_field("day_of_month", want.day_of_month, o_out_data.day_of_month);
                check_field("nanoseconds_out", want.nanoseconds_out,
                            o_out_data.nanoseconds_out);
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Extremes of both input fields, out-of-range nanoseconds included.
    task automatic test_field_extremes();
        send_request(0, 30'd0);
        send_request(MAX_EPOCH, 30'd999999999);
        send_request(1, 30'h3FFFFFFF);
        send_request(MAX_EPOCH - 1, 30'd1000000000);
        send_request(59, 30'h2AAAAAAA);
        send_request(SECS_PER_DAY - 1, 30'h15555555);
        send_request(SECS_PER_DAY, 30'd1);
        send_request(64'h40000000, 30'h20000000);
    endtask

    // Leap days, year ends and century boundaries reachable in 31 bits.
    task automatic test_calendar_edges();
        send_request(68169600, 30'd500);            // 1972-02-29
        send_request(94607999 + SECS_PER_DAY, 30'd7); // 1972-12-31 end
        send_request(94694400, 30'd0);              // 1973-01-01
        send_request(946684799, 30'd999999999);     // 1999-12-31 23:59:59
        send_request(946684800, 30'd0);             // 2000-01-01
        send_request(951782400, 30'd123456789);     // 2000-02-29
        send_request(951868800, 30'd42);            // 2000-03-01
        send_request(978307199, 30'd999999998);     // 2000-12-31, day 365
        send_request(978307200, 30'd3);             // 2001-01-01
        send_request(1078099200 - 1, 30'd11);       // 2004-02-29 end
        send_request(2145916799, 30'd999);          // 2037-12-31 end
        send_request(2145916800, 30'd1);            // 2038-01-01
    endtask

    task automatic test_random_stream(int count);
        longint epoch, days;
        logic [29:0] nsec;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                epoch = longint'($urandom) & MAX_EPOCH;
            end else if (pick < 90) begin
                // near a year start, end of February or a year end
                days = year_start_days($urandom_range(2038, 1970));
                case ($urandom_range(4))
                    0: days -= 1;
                    1: days += 58;
                    2: days += 59;
                    3: days += 60;
                    default: days += 0;
                endcase
                if (days < 0)
                    days = 0;
                epoch = days * SECS_PER_DAY + $urandom_range(86399);
                if (epoch > MAX_EPOCH)
                    epoch = MAX_EPOCH - $urandom_range(86399);
            end else begin
                epoch = $urandom_range(1) ? $urandom_range(100000)
                                          : MAX_EPOCH - $urandom_range(100000);
            end
            nsec = $urandom_range(1) ? 30'($urandom) : 30'($urandom_range(999999999));
            send_request(epoch, nsec);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 77;
        test_field_extremes();
        test_calendar_edges();
        test_random_stream(RANDOM_ITEMS);

        send_idle_pct = 77;
        recv_idle_pct = 35;
        test_random_stream(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
